### rtl/assert_macros.svh
// Assertion macros shared by the RTL files of the setpoint generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_AT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checks that a condition never holds at a rising clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

### rtl/masg_pkg.sv
// Types, constants and helper functions of the motor angle setpoint generator.
package masg_pkg;

    localparam int TABLE_STEPS = 256;
    localparam int IDX_W       = (TABLE_STEPS > 1) ? $clog2(TABLE_STEPS) : 1;

    localparam int Q_W    = 26;
    localparam int TV_W   = 25;
    localparam int MODE_W = 3;
    localparam int REQ_W  = 2;
    localparam int TI_W   = 8;
    localparam int TICK_W = 7;
    localparam int DEC_W  = 4;

    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 56;

    localparam logic signed [Q_W:0] Q_FULL = 27'sd23592960;
    localparam logic signed [Q_W:0] Q_MAX  = 27'sd23592959;
    localparam logic signed [Q_W:0] Q_MIN  = -27'sd23592960;
    localparam logic [TV_W-1:0]     TV_MAX = 25'd23592959;

    localparam logic [TICK_W-1:0] TICK_LAST = 7'd100;
    localparam logic [DEC_W-1:0]  DEC_LAST  = 4'd9;

    localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CMD   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TABLE = 2'd2;

    localparam logic [MODE_W-1:0] MODE_DISABLED = 3'd0;
    localparam logic [MODE_W-1:0] MODE_STATIC   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SPEED    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SINE     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ACCEL    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_POSITION = 3'd5;

    typedef logic signed [Q_W-1:0] q_t;
    typedef logic signed [Q_W:0]   qw_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        q_t                pos;
        q_t                vel;
        q_t                tgt;
        q_t                stp;
        logic [TICK_W-1:0] tick;
        logic [DEC_W-1:0]  dec;
        logic [IDX_W-1:0]  sidx;
    } masg_state_t;

    typedef struct packed {
        logic [REQ_W-1:0]  kind;
        logic [MODE_W-1:0] mode;
        q_t                value;
        q_t                step;
        logic [TI_W-1:0]   tindex;
        logic [TV_W-1:0]   tvalue;
    } masg_req_t;

    typedef struct packed {
        logic             report;
        logic             ram_we;
        logic [IDX_W-1:0] waddr;
        logic [TV_W-1:0]  wdata;
        logic             from_ram;
    } masg_ctrl_t;

    function automatic q_t sat_q(input qw_t v);
        q_t r;
        if (v > Q_MAX)
        begin
            r = q_t'(Q_MAX);
        end
        else if (v < Q_MIN)
        begin
            r = q_t'(Q_MIN);
        end
        else
        begin
            r = q_t'(v);
        end
        return r;
    endfunction

endpackage

### rtl/masg_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module masg_ram #(
    parameter int WIDTH = 25,
    parameter int DEPTH = 256
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/masg_update.sv
// Next-state logic of the setpoint generator for one tick, command or table write.
module masg_update (
    input  masg_pkg::masg_state_t st,
    input  masg_pkg::masg_req_t   req,
    output masg_pkg::masg_state_t nxt,
    output masg_pkg::masg_ctrl_t  ctl
);

    import masg_pkg::*;

    qw_t              p;
    qw_t              v;
    qw_t              t;
    qw_t              s;
    qw_t              p2;
    qw_t              q;
    qw_t              ramp_p;
    q_t               spd_pos;
    q_t               v_up;
    q_t               v_dn;
    q_t               v_new;
    q_t               ramp_pos;
    q_t               val_sat;
    q_t               stp_sat;
    logic [TV_W-1:0]  tv_sat;
    logic             tindex_ok;
    logic             ramp_ok;
    logic             tick_wrap;
    logic             accel4;
    logic             up5;
    logic             dn5;
    logic             acc5;
    logic             dec5;
    logic             decel;
    logic [IDX_W-1:0] sidx_inc;

    assign p  = qw_t'(st.pos);
    assign v  = qw_t'(st.vel);
    assign t  = qw_t'(st.tgt);
    assign s  = qw_t'(st.stp);
    assign p2 = {st.pos, 1'b0};

    assign q = p + v;

    always_comb
    begin
        if (q >= Q_FULL)
        begin
            spd_pos = q_t'(q - Q_FULL);
        end
        else if (q < -Q_FULL)
        begin
            spd_pos = q_t'(q + Q_FULL + Q_FULL);
        end
        else if (q < 0)
        begin
            spd_pos = q_t'(q + Q_FULL);
        end
        else
        begin
            spd_pos = q_t'(q);
        end
    end

    assign accel4 = ((t > v) && (s > 0)) || ((t < v) && (s < 0));
    assign up5    = (t > p) && (s > 0);
    assign dn5    = (t < p) && (s < 0);
    assign acc5   = (up5 && (p2 <= t)) || (dn5 && (p2 >= t));
    assign dec5   = (up5 && (p2 > t)) || (dn5 && (p2 < t));
    assign decel  = (st.mode == MODE_POSITION) && dec5;

    assign v_up     = sat_q(v + s);
    assign v_dn     = sat_q(v - s);
    assign v_new    = decel ? v_dn : v_up;
    assign ramp_p   = p + qw_t'(v_new);
    assign ramp_pos = (ramp_p > Q_FULL) ? '0 : sat_q(ramp_p);

    assign ramp_ok   = (st.dec != '0);
    assign tick_wrap = (st.tick == TICK_LAST);
    assign sidx_inc  = (st.sidx == IDX_W'(TABLE_STEPS - 1)) ? '0 : st.sidx + 1'b1;

    assign val_sat   = sat_q(qw_t'(req.value));
    assign stp_sat   = sat_q(qw_t'(req.step));
    assign tv_sat    = (req.tvalue > TV_MAX) ? TV_MAX : req.tvalue;
    assign tindex_ok = (32'(req.tindex) < TABLE_STEPS);

    always_comb
    begin
        nxt          = st;
        ctl          = '0;
        ctl.waddr    = IDX_W'(req.tindex);
        ctl.wdata    = tv_sat;
        unique case (req.kind)
            REQ_TICK:
            begin
                nxt.tick   = tick_wrap ? '0 : st.tick + 1'b1;
                nxt.dec    = (tick_wrap || (st.dec == DEC_LAST)) ? '0 : st.dec + 1'b1;
                ctl.report = tick_wrap;
                unique case (st.mode)
                    MODE_SPEED:
                    begin
                        nxt.pos = spd_pos;
                    end
                    MODE_SINE:
                    begin
                        nxt.sidx     = sidx_inc;
                        ctl.from_ram = 1'b1;
                    end
                    MODE_ACCEL:
                    begin
                        if (accel4)
                        begin
                            if (ramp_ok)
                            begin
                                nxt.vel = v_new;
                                nxt.pos = ramp_pos;
                            end
                        end
                        else
                        begin
                            nxt.mode = MODE_SPEED;
                        end
                    end
                    MODE_POSITION:
                    begin
                        if (acc5 || dec5)
                        begin
                            if (ramp_ok)
                            begin
                                nxt.vel = v_new;
                                nxt.pos = ramp_pos;
                            end
                        end
                        else
                        begin
                            nxt.vel = '0;
                            nxt.pos = st.tgt;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            REQ_CMD:
            begin
                unique case (req.mode)
                    MODE_DISABLED:
                    begin
                        nxt.mode = MODE_DISABLED;
                    end
                    MODE_STATIC:
                    begin
                        nxt.mode = MODE_STATIC;
                        nxt.pos  = val_sat;
                    end
                    MODE_SPEED:
                    begin
                        nxt.mode = MODE_SPEED;
                        nxt.vel  = val_sat;
                    end
                    MODE_SINE:
                    begin
                        nxt.mode = MODE_SINE;
                    end
                    MODE_ACCEL:
                    begin
                        nxt.mode = MODE_ACCEL;
                        nxt.tgt  = val_sat;
                        nxt.stp  = stp_sat;
                    end
                    MODE_POSITION:
                    begin
                        nxt.mode = MODE_POSITION;
                        nxt.tgt  = val_sat;
                        nxt.stp  = stp_sat;
                        nxt.vel  = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            REQ_TABLE:
            begin
                ctl.ram_we = tindex_ok;
            end
            default:
            begin
            end
        endcase
    end

endmodule

### rtl/motor_angle_setpoint_generator_top.sv
// Top level of the motor angle setpoint generator: state, sine table RAM and output stage.
// Latency: a request's result is valid in the cycle after the request is taken.
// Throughput: one request per cycle while the output is not stalled; the sine table
// RAM is read at the accept edge and its registered data is forwarded into the next
// request's angle. The output register holds a result while the output side stalls.
// Reset clears mode, angle, velocity, target, step, counters and valid flags at once;
// sine table contents are undefined until written and no clearing pass runs.
`include "assert_macros.svh"

module motor_angle_setpoint_generator_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // cmd_mode, cmd_value, cmd_step, table_index, table_value
    input  logic [masg_pkg::IN_DATA_W-1:0]   s_tdata,
    // req_type
    input  logic [masg_pkg::REQ_W-1:0]       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // setpoint_angle, current_velocity, active_mode, report_tick
    output logic [masg_pkg::OUT_DATA_W-1:0]  m_tdata
);

    import masg_pkg::*;

    masg_state_t       st_reg;
    masg_state_t       st_next;
    masg_state_t       st_eff;
    masg_req_t         req;
    masg_ctrl_t        ctl;
    logic              pend_reg;
    logic              s_acc;
    logic [TV_W-1:0]   rdata;
    logic              out_valid_reg;
    logic              out_ram_reg;
    q_t                out_pos_reg;
    q_t                out_vel_reg;
    logic [MODE_W-1:0] out_mode_reg;
    logic              out_report_reg;
    q_t                out_angle;

    assign s_tready = !out_valid_reg || m_tready;
    assign s_acc    = s_tvalid && s_tready;

    assign req.kind   = s_tuser;
    assign req.mode   = s_tdata[2:0];
    assign req.value  = s_tdata[28:3];
    assign req.step   = s_tdata[54:29];
    assign req.tindex = s_tdata[62:55];
    assign req.tvalue = s_tdata[87:63];

    // A sine tick leaves its angle in the RAM read register until the next request.
    always_comb
    begin
        st_eff = st_reg;
        if (pend_reg)
        begin
            st_eff.pos = q_t'({1'b0, rdata});
        end
    end

    masg_update u_update (
        .st  (st_eff),
        .req (req),
        .nxt (st_next),
        .ctl (ctl)
    );

    masg_ram #(
        .WIDTH (TV_W),
        .DEPTH (TABLE_STEPS)
    ) u_sine_ram (
        .clk   (clk),
        .we    (s_acc && ctl.ram_we),
        .waddr (ctl.waddr),
        .wdata (ctl.wdata),
        .re    (s_acc),
        .raddr (st_reg.sidx),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_acc)
            begin
                st_reg   <= st_next;
                pend_reg <= ctl.from_ram;
            end
            if (s_acc)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            out_pos_reg    <= st_next.pos;
            out_vel_reg    <= st_next.vel;
            out_mode_reg   <= st_next.mode;
            out_report_reg <= ctl.report;
            out_ram_reg    <= ctl.from_ram;
        end
    end

    assign out_angle = out_ram_reg ? q_t'({1'b0, rdata}) : out_pos_reg;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {out_report_reg, out_mode_reg, out_vel_reg, out_angle};

    `ASSERT_NEVER(a_pend_in_sine, pend_reg && (st_reg.mode != MODE_SINE), "forwarded angle outside sine mode")
    `ASSERT_NEVER(a_tick_range, st_reg.tick > TICK_LAST, "tick counter beyond its wrap value")
    `ASSERT_AT_CLK(a_tick_wrap, s_acc && (req.kind == REQ_TICK) && (st_reg.tick == TICK_LAST) |=> (st_reg.tick == '0) && (st_reg.dec == '0), "tick counters did not wrap together")
    `ASSERT_AT_CLK(a_rdata_hold, out_valid_reg && !m_tready && out_ram_reg |=> $stable(rdata), "sine read data changed under a stalled result")
    `ASSERT_AT_CLK(a_result_follows, s_acc |=> m_tvalid, "accepted request produced no result")

endmodule
